[rtl/core/aplr_pkg.sv]
// Shared types, codes and lookup functions for the packet loss recovery planner.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package aplr_pkg;

	localparam int MAX_GAP_DEF     = 7;
	localparam int MAX_PAYLOAD_DEF = 1275;

	localparam int NUM_TICKS = 6;
	localparam int TIDX_W    = 3;

	typedef logic [2:0]        action_t;
	typedef logic [2:0]        rate_t;
	typedef logic [TIDX_W-1:0] tidx_t;

	localparam action_t ACT_REJECT  = 3'd0;
	localparam action_t ACT_DROP    = 3'd1;
	localparam action_t ACT_CONCEAL = 3'd2;
	localparam action_t ACT_FEC     = 3'd3;
	localparam action_t ACT_DECODE  = 3'd4;

	localparam rate_t RATE_8K  = 3'd0;
	localparam rate_t RATE_12K = 3'd1;
	localparam rate_t RATE_16K = 3'd2;
	localparam rate_t RATE_24K = 3'd3;
	localparam rate_t RATE_48K = 3'd4;

	localparam logic [15:0] SEQ_HALF = 16'h8000;
	localparam logic [31:0] TICK_MAX = 32'd2880;

	typedef struct packed {
		logic [15:0] sequence_req;
		logic [31:0] timestamp;
		logic [10:0] packet_size;
		logic [12:0] packet_samples;
	} in_word_t;

	typedef struct packed {
		action_t     action;
		logic [12:0] frame_samples;
		logic        reset_decoder;
		logic        last;
		logic [31:0] late_count;
		logic [31:0] conceal_count;
		logic [31:0] fec_count;
		logic [31:0] discontinuity_count;
	} out_word_t;

	typedef struct packed {
		logic    capture;
		logic    calc_exp;
		logic    calc_miss;
		logic    search_clr;
		logic    search_step;
		logic    loss_clr;
		logic    load;
		action_t action;
		logic    rst;
	} ctrl_cmd_t;

	typedef struct packed {
		logic bad;
		logic late;
		logic gap_ok;
		logic jump;
		logic hit;
		logic tidx_last;
		logic loss_last;
		logic slot_free;
	} dp_stat_t;

	function automatic rate_t rate_code(input logic [15:0] hz);
		rate_t r;
		unique case (hz)
			16'd8000:  r = RATE_8K;
			16'd12000: r = RATE_12K;
			16'd16000: r = RATE_16K;
			16'd24000: r = RATE_24K;
			default:   r = RATE_48K;
		endcase
		return r;
	endfunction

	// full decode buffer: rate * 120 ms
	function automatic logic [12:0] full_samples(input rate_t r);
		logic [12:0] n;
		unique case (r)
			RATE_8K:  n = 13'd960;
			RATE_12K: n = 13'd1440;
			RATE_16K: n = 13'd1920;
			RATE_24K: n = 13'd2880;
			default:  n = 13'd5760;
		endcase
		return n;
	endfunction

	// 48 kHz ticks per decoder sample
	function automatic logic [2:0] tick_mult(input rate_t r);
		logic [2:0] m;
		unique case (r)
			RATE_8K:  m = 3'd6;
			RATE_12K: m = 3'd4;
			RATE_16K: m = 3'd3;
			RATE_24K: m = 3'd2;
			default:  m = 3'd1;
		endcase
		return m;
	endfunction

	function automatic logic [11:0] tick_len(input tidx_t t);
		logic [11:0] n;
		unique case (t)
			3'd0:    n = 12'd120;
			3'd1:    n = 12'd240;
			3'd2:    n = 12'd480;
			3'd3:    n = 12'd960;
			3'd4:    n = 12'd1920;
			default: n = 12'd2880;
		endcase
		return n;
	endfunction

	// lost frame length at decoder rate: ticks * rate / 48000
	function automatic logic [12:0] loss_len(input rate_t r, input tidx_t t);
		logic [12:0] base;
		logic [4:0]  mul;
		unique case (r)
			RATE_8K:  base = 13'd20;
			RATE_12K: base = 13'd30;
			RATE_16K: base = 13'd40;
			RATE_24K: base = 13'd60;
			default:  base = 13'd120;
		endcase
		unique case (t)
			3'd0:    mul = 5'd1;
			3'd1:    mul = 5'd2;
			3'd2:    mul = 5'd4;
			3'd3:    mul = 5'd8;
			3'd4:    mul = 5'd16;
			default: mul = 5'd24;
		endcase
		return 13'(base * 13'(mul));
	endfunction

endpackage

[rtl/core/aplr_in_if.sv]
// Packet channel: valid/ready handshake carrying one received packet word.
// Depends on aplr_pkg for the payload type.
interface aplr_in_if;
	logic               valid;
	logic               ready;
	aplr_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/aplr_out_if.sv]
// Command channel: valid/ready handshake carrying one decoder command word.
// Depends on aplr_pkg for the payload type.
interface aplr_out_if;
	logic                valid;
	logic                ready;
	aplr_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/audio_packet_loss_recovery_planner.sv]
// Packet loss recovery planner: one packet word in, one to MAX_GAP command words out.
// The controller takes one packet at a time and accepts the next only after its last command word is loaded;
// it loads at most one command word per cycle, and only while the output slot is free.
// Reset (arst_n low) clears history, counters and handshake state; sample rate returns to 48 kHz.
// Depends on aplr_pkg, aplr_in_if, aplr_out_if, aplr_dp and aplr_ctrl.
module audio_packet_loss_recovery_planner #(
	parameter int MAX_GAP     = aplr_pkg::MAX_GAP_DEF,
	parameter int MAX_PAYLOAD = aplr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	aplr_in_if.sink     pkt,
	aplr_out_if.source  plan
);

	aplr_pkg::ctrl_cmd_t ctrl_cmd;
	aplr_pkg::dp_stat_t  dp_stat;
	logic                pkt_ready;
	logic                plan_valid;
	aplr_pkg::out_word_t plan_word;

	aplr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pkt.valid),
		.in_ready (pkt_ready),
		.stat     (dp_stat),
		.cmd      (ctrl_cmd)
	);

	aplr_dp #(
		.MAX_GAP     (MAX_GAP),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_word   (pkt.data),
		.cmd       (ctrl_cmd),
		.stat      (dp_stat),
		.out_valid (plan_valid),
		.out_ready (plan.ready),
		.out_word  (plan_word)
	);

	assign pkt.ready  = pkt_ready;
	assign plan.valid = plan_valid;
	assign plan.data  = plan_word;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.load |-> dp_stat.slot_free)
		else $error("command word loaded over a waiting word");

	a_one_packet: assert property (@(posedge clk) disable iff (!arst_n)
		pkt.valid && pkt.ready |=> !pkt.ready)
		else $error("second packet taken while one is in work");

	a_loss_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		plan.valid && (plan.data.action == aplr_pkg::ACT_CONCEAL ||
			plan.data.action == aplr_pkg::ACT_FEC)
		|-> !plan.data.last && !plan.data.reset_decoder)
		else $error("lost-frame word marked last or with decoder reset");

	a_ready_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.load && ctrl_cmd.action == aplr_pkg::ACT_DECODE |=> pkt.ready)
		else $error("planner not ready after decode word");
`endif

endmodule

[rtl/core/aplr_dp.sv]
// Datapath: packet capture, sequence/timestamp arithmetic, frame search, counters, output word.
// Depends on aplr_pkg; driven by aplr_ctrl through ctrl_cmd_t, reports through dp_stat_t.
module aplr_dp #(
	parameter int MAX_GAP     = aplr_pkg::MAX_GAP_DEF,
	parameter int MAX_PAYLOAD = aplr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data,
	input  aplr_pkg::in_word_t   in_word,
	input  aplr_pkg::ctrl_cmd_t  cmd,
	output aplr_pkg::dp_stat_t   stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output aplr_pkg::out_word_t  out_word
);

	localparam int          GAP_W       = $clog2(MAX_GAP);
	localparam int          PROD_W      = GAP_W + 12;
	localparam logic [10:0] PAYLOAD_MAX = 11'(MAX_PAYLOAD);
	localparam logic [15:0] GAP_MAX     = 16'(MAX_GAP);

	aplr_pkg::rate_t rate_q;

	logic [15:0] seq_q;
	logic [31:0] ts_q;
	logic [10:0] size_q;
	logic [12:0] smp_q;

	logic        seen_q;
	logic [15:0] prev_seq_q;
	logic [31:0] prev_ts_q;
	logic [12:0] prev_smp_q;

	logic [31:0] exp_q;
	logic [15:0] dist_q;
	logic        bad_q;
	logic [31:0] miss_q;

	aplr_pkg::tidx_t tidx_q;
	logic [GAP_W-1:0] loss_q;

	logic [31:0] late_q, conc_q, fec_q, disc_q;
	logic [31:0] late_nx, conc_nx, fec_nx, disc_nx;

	logic                out_valid_q;
	aplr_pkg::out_word_t out_word_q;

	logic [GAP_W-1:0]  gap;
	logic [PROD_W-1:0] prod;
	logic              is_loss;
	logic              is_dec;
	logic [12:0]       frame_nx;

	assign gap  = GAP_W'(dist_q - 16'd1);
	assign prod = PROD_W'(gap) * PROD_W'(aplr_pkg::tick_len(tidx_q));

	assign is_loss = cmd.action == aplr_pkg::ACT_CONCEAL || cmd.action == aplr_pkg::ACT_FEC;
	assign is_dec  = cmd.action == aplr_pkg::ACT_DECODE;

	always_comb begin
		stat.bad       = bad_q;
		stat.late      = seen_q && (dist_q == 16'd0 || dist_q >= aplr_pkg::SEQ_HALF);
		stat.gap_ok    = seen_q && dist_q > 16'd1 && dist_q <= GAP_MAX &&
			miss_q != 32'd0 && miss_q <= aplr_pkg::TICK_MAX;
		stat.jump      = seen_q && (dist_q > 16'd1 || miss_q != 32'd0);
		stat.hit       = 32'(prod) == miss_q;
		stat.tidx_last = tidx_q == aplr_pkg::tidx_t'(aplr_pkg::NUM_TICKS - 1);
		stat.loss_last = loss_q == gap;
		stat.slot_free = !out_valid_q || out_ready;
	end

	always_comb begin
		late_nx = late_q + 32'(cmd.load && cmd.action == aplr_pkg::ACT_DROP);
		conc_nx = conc_q + 32'(cmd.load && cmd.action == aplr_pkg::ACT_CONCEAL);
		fec_nx  = fec_q + 32'(cmd.load && cmd.action == aplr_pkg::ACT_FEC);
		disc_nx = disc_q + 32'(cmd.load && is_dec && cmd.rst);
		if (is_loss) begin
			frame_nx = aplr_pkg::loss_len(rate_q, tidx_q);
		end else if (is_dec) begin
			frame_nx = aplr_pkg::full_samples(rate_q);
		end else begin
			frame_nx = 13'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= aplr_pkg::RATE_48K;
			seen_q      <= 1'b0;
			prev_seq_q  <= 16'd0;
			prev_ts_q   <= 32'd0;
			prev_smp_q  <= 13'd0;
			late_q      <= 32'd0;
			conc_q      <= 32'd0;
			fec_q       <= 32'd0;
			disc_q      <= 32'd0;
			tidx_q      <= '0;
			loss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_q <= aplr_pkg::rate_code(cfg_data);
			end
			if (cmd.search_clr) begin
				tidx_q <= '0;
			end else if (cmd.search_step) begin
				tidx_q <= tidx_q + aplr_pkg::tidx_t'(1);
			end
			if (cmd.loss_clr) begin
				loss_q <= GAP_W'(1);
			end else if (cmd.load && is_loss) begin
				loss_q <= loss_q + GAP_W'(1);
			end
			if (cmd.load) begin
				late_q      <= late_nx;
				conc_q      <= conc_nx;
				fec_q       <= fec_nx;
				disc_q      <= disc_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load && is_dec) begin
				seen_q     <= 1'b1;
				prev_seq_q <= seq_q;
				prev_ts_q  <= ts_q;
				prev_smp_q <= smp_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seq_q  <= in_word.sequence_req;
			ts_q   <= in_word.timestamp;
			size_q <= in_word.packet_size;
			smp_q  <= in_word.packet_samples;
		end
		if (cmd.calc_exp) begin
			exp_q  <= prev_ts_q + 32'(16'(prev_smp_q) * 16'(aplr_pkg::tick_mult(rate_q)));
			dist_q <= seq_q - prev_seq_q;
			bad_q  <= size_q == 11'd0 || size_q > PAYLOAD_MAX || smp_q == 13'd0 ||
				smp_q > aplr_pkg::full_samples(rate_q);
		end
		if (cmd.calc_miss) begin
			miss_q <= ts_q - exp_q;
		end
		if (cmd.load) begin
			out_word_q.action              <= cmd.action;
			out_word_q.frame_samples       <= frame_nx;
			out_word_q.reset_decoder       <= is_dec && cmd.rst;
			out_word_q.last                <= !is_loss;
			out_word_q.late_count          <= late_nx;
			out_word_q.conceal_count       <= conc_nx;
			out_word_q.fec_count           <= fec_nx;
			out_word_q.discontinuity_count <= disc_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

[rtl/core/aplr_ctrl.sv]
// Controller: sequences capture, classification, frame search and command issue for one packet.
// Depends on aplr_pkg; steers aplr_dp through ctrl_cmd_t and reads dp_stat_t.
module aplr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  aplr_pkg::dp_stat_t  stat,
	output aplr_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXP    = 3'd1;
	localparam logic [2:0] S_MISS   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_SEARCH = 3'd4;
	localparam logic [2:0] S_LOSS   = 3'd5;
	localparam logic [2:0] S_DEC    = 3'd6;
	localparam logic [2:0] S_ONE    = 3'd7;

	logic [2:0]        state_q, state_d;
	logic              rst_q, rst_d;
	aplr_pkg::action_t one_act_q, one_act_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d   = state_q;
		rst_d     = rst_q;
		one_act_d = one_act_q;
		cmd       = '0;
		cmd.action = aplr_pkg::ACT_DECODE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXP;
				end
			end
			S_EXP: begin
				cmd.calc_exp = 1'b1;
				state_d      = S_MISS;
			end
			S_MISS: begin
				cmd.calc_miss = 1'b1;
				state_d       = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.search_clr = 1'b1;
				cmd.loss_clr   = 1'b1;
				priority if (stat.bad) begin
					one_act_d = aplr_pkg::ACT_REJECT;
					state_d   = S_ONE;
				end else if (stat.late) begin
					one_act_d = aplr_pkg::ACT_DROP;
					state_d   = S_ONE;
				end else if (stat.gap_ok) begin
					state_d = S_SEARCH;
				end else begin
					rst_d   = stat.jump;
					state_d = S_DEC;
				end
			end
			S_SEARCH: begin
				priority if (stat.hit) begin
					state_d = S_LOSS;
				end else if (stat.tidx_last) begin
					rst_d   = 1'b1;
					state_d = S_DEC;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			S_LOSS: begin
				cmd.action = stat.loss_last ? aplr_pkg::ACT_FEC : aplr_pkg::ACT_CONCEAL;
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					if (stat.loss_last) begin
						rst_d   = 1'b0;
						state_d = S_DEC;
					end
				end
			end
			S_DEC: begin
				cmd.rst = rst_q;
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_ONE: begin
				cmd.action = one_act_q;
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rst_q     <= 1'b0;
			one_act_q <= aplr_pkg::ACT_REJECT;
		end else begin
			state_q   <= state_d;
			rst_q     <= rst_d;
			one_act_q <= one_act_d;
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the packet loss recovery planner: feeds packet words through the
// packet channel and checks every command word against its own model of history and counters.
// Depends on aplr_pkg, aplr_in_if, aplr_out_if and audio_packet_loss_recovery_planner.
module tb;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned PHASE_ITEMS  = 45;
	localparam int unsigned NUM_PHASES   = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;

	aplr_in_if  pkt_ch ();
	aplr_out_if plan_ch ();

	audio_packet_loss_recovery_planner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.pkt      (pkt_ch),
		.plan     (plan_ch)
	);

	// model of the planner
	logic [15:0] rate_reg   = 16'd48000;
	logic        hist_valid = 1'b0;
	logic [15:0] hist_seq   = '0;
	logic [31:0] hist_ts    = '0;
	logic [12:0] hist_len   = '0;
	logic [31:0] n_late     = '0;
	logic [31:0] n_conceal  = '0;
	logic [31:0] n_fec      = '0;
	logic [31:0] n_discont  = '0;

	aplr_pkg::out_word_t due_cmds[$];
	aplr_pkg::in_word_t  pkt_backlog[$];

	// stream position as seen by the stimulus side
	logic [15:0] gen_seq = '0;
	logic [31:0] gen_ts  = '0;
	logic [12:0] gen_len = '0;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        long_hold_go   = 1'b0;
	int unsigned hold_left      = 0;
	int unsigned fails          = 0;
	int unsigned cycles         = 0;

	int unsigned phase_rate[NUM_PHASES] = '{48000, 8000, 16000, 24000, 12000, 0, 65535, 48000};

	function automatic logic [31:0] rate_hz(input logic [15:0] r);
		case (r)
			16'd8000, 16'd12000, 16'd16000, 16'd24000, 16'd48000: return 32'(r);
			default: return 32'd48000;
		endcase
	endfunction

	function automatic logic [31:0] full_len(input logic [31:0] hz);
		return hz * 32'd120 / 32'd1000;
	endfunction

	function automatic bit legal_ticks(input logic [31:0] t);
		return t == 120 || t == 240 || t == 480 || t == 960 || t == 1920 || t == 2880;
	endfunction

	function automatic aplr_pkg::out_word_t cmd_word(input aplr_pkg::action_t a,
			input logic [12:0] n, input logic rst, input logic fin);
		aplr_pkg::out_word_t w;
		w.action              = a;
		w.frame_samples       = n;
		w.reset_decoder       = rst;
		w.last                = fin;
		w.late_count          = n_late;
		w.conceal_count       = n_conceal;
		w.fec_count           = n_fec;
		w.discontinuity_count = n_discont;
		return w;
	endfunction

	task automatic plan_packet(input aplr_pkg::in_word_t w);
		logic [31:0] hz, full, miss, per;
		logic [15:0] seq_step;
		logic [12:0] lost;
		logic        rst;
		hz       = rate_hz(rate_reg);
		full     = full_len(hz);
		rst      = 1'b0;
		seq_step = w.sequence_req - hist_seq;
		miss     = w.timestamp - (hist_ts + 32'(hist_len) * (32'd48000 / hz));
		if (w.packet_size == 0 || w.packet_size > aplr_pkg::MAX_PAYLOAD_DEF
				|| w.packet_samples == 0 || 32'(w.packet_samples) > full) begin
			due_cmds.push_back(cmd_word(aplr_pkg::ACT_REJECT, '0, 1'b0, 1'b1));
		end else if (hist_valid && (seq_step == 0 || seq_step >= aplr_pkg::SEQ_HALF)) begin
			n_late++;
			due_cmds.push_back(cmd_word(aplr_pkg::ACT_DROP, '0, 1'b0, 1'b1));
		end else begin
			if (hist_valid && seq_step > 1 && seq_step <= aplr_pkg::MAX_GAP_DEF && miss != 0
					&& miss <= aplr_pkg::TICK_MAX && miss % (seq_step - 1) == 0) begin
				per = miss / (seq_step - 1);
				if (legal_ticks(per)) begin
					lost = 13'(per * hz / 32'd48000);
					for (int i = 1; i < seq_step; i++) begin
						if (i == seq_step - 1) begin
							n_fec++;
							due_cmds.push_back(cmd_word(aplr_pkg::ACT_FEC, lost, 1'b0, 1'b0));
						end else begin
							n_conceal++;
							due_cmds.push_back(cmd_word(aplr_pkg::ACT_CONCEAL, lost, 1'b0,
								1'b0));
						end
					end
				end else begin
					rst = 1'b1;
				end
			end else if (hist_valid && (seq_step > 1 || miss != 0)) begin
				rst = 1'b1;
			end
			if (rst)
				n_discont++;
			due_cmds.push_back(cmd_word(aplr_pkg::ACT_DECODE, 13'(full), rst, 1'b1));
			hist_valid = 1'b1;
			hist_seq   = w.sequence_req;
			hist_ts    = w.timestamp;
			hist_len   = w.packet_samples;
		end
	endtask

	function automatic void flag(input string msg);
		fails++;
		if (fails <= 10)
			$display("%0t: mismatch: %s", $time, msg);
	endfunction

	function automatic void cmp_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			flag($sformatf("%s expected %0d, got %0d", name, want, got));
	endfunction

	task automatic check_cmd(input aplr_pkg::out_word_t got);
		aplr_pkg::out_word_t want;
		if (due_cmds.size() == 0) begin
			flag($sformatf("command word with nothing due, action %0d", got.action));
			return;
		end
		want = due_cmds.pop_front();
		cmp_field("action", 32'(want.action), 32'(got.action));
		cmp_field("frame_samples", 32'(want.frame_samples), 32'(got.frame_samples));
		cmp_field("reset_decoder", 32'(want.reset_decoder), 32'(got.reset_decoder));
		cmp_field("last", 32'(want.last), 32'(got.last));
		cmp_field("late_count", want.late_count, got.late_count);
		cmp_field("conceal_count", want.conceal_count, got.conceal_count);
		cmp_field("fec_count", want.fec_count, got.fec_count);
		cmp_field("discontinuity_count", want.discontinuity_count, got.discontinuity_count);
	endtask

	function automatic logic [31:0] pick_ticks();
		case ($urandom_range(5))
			0: return 32'd120;
			1: return 32'd240;
			2: return 32'd480;
			3: return 32'd960;
			4: return 32'd1920;
			default: return 32'd2880;
		endcase
	endfunction

	function automatic logic [12:0] pick_len();
		logic [31:0] hz;
		hz = rate_hz(rate_reg);
		if ($urandom_range(4) == 0)
			return 13'($urandom_range(full_len(hz), 1));
		return 13'(pick_ticks() * hz / 32'd48000);
	endfunction

	function automatic logic [10:0] pick_size();
		return 11'($urandom_range(aplr_pkg::MAX_PAYLOAD_DEF, 1));
	endfunction

	task automatic send(input logic [15:0] seq, input logic [31:0] ts, input logic [10:0] size,
			input logic [12:0] len);
		aplr_pkg::in_word_t w;
		w.sequence_req   = seq;
		w.timestamp      = ts;
		w.packet_size    = size;
		w.packet_samples = len;
		pkt_backlog.push_back(w);
	endtask

	// advance the stream by d sequence numbers and miss ticks beyond the expected timestamp
	task automatic send_next(input logic [15:0] d, input logic [31:0] miss,
			input logic [10:0] size, input logic [12:0] len);
		logic [31:0] ts;
		ts = gen_ts + 32'(gen_len) * (32'd48000 / rate_hz(rate_reg)) + miss;
		send(gen_seq + d, ts, size, len);
		gen_seq = gen_seq + d;
		gen_ts  = ts;
		gen_len = len;
	endtask

	task automatic send_random();
		int unsigned r, d;
		logic [31:0] t, full;
		logic [15:0] seq_step;
		aplr_pkg::in_word_t w;
		full = full_len(rate_hz(rate_reg));
		r = $urandom_range(99);
		if (r < 38) begin
			send_next(16'd1, '0, pick_size(), pick_len());
		end else if (r < 58) begin
			d = $urandom_range(aplr_pkg::MAX_GAP_DEF, 2);
			t = pick_ticks();
			while (t * (d - 1) > aplr_pkg::TICK_MAX)
				t = pick_ticks();
			send_next(16'(d), t * (d - 1), pick_size(), pick_len());
		end else if (r < 63) begin
			d = $urandom_range(aplr_pkg::MAX_GAP_DEF, 2);
			send_next(16'(d), (d - 1) * $urandom_range(aplr_pkg::TICK_MAX / (d - 1), 1),
				pick_size(), pick_len());
		end else if (r < 66) begin
			d = $urandom_range(aplr_pkg::MAX_GAP_DEF, 2);
			send_next(16'(d), $urandom_range(3200, 0), pick_size(), pick_len());
		end else if (r < 69) begin
			send_next(16'($urandom_range(32767, aplr_pkg::MAX_GAP_DEF + 1)),
				$urandom_range(1) ? 32'd0 : 32'($urandom), pick_size(), pick_len());
		end else if (r < 72) begin
			send_next(16'd1, $urandom, pick_size(), pick_len());
		end else if (r < 78) begin
			send(gen_seq - 16'($urandom_range(32768, 0)), $urandom, pick_size(), pick_len());
		end else if (r < 84) begin
			send(gen_seq + 16'd1, $urandom,
				$urandom_range(1) ? 11'd0
					: 11'($urandom_range(2047, aplr_pkg::MAX_PAYLOAD_DEF + 1)),
				pick_len());
		end else if (r < 90) begin
			send(gen_seq + 16'd1, $urandom, pick_size(),
				$urandom_range(1) ? 13'd0 : 13'($urandom_range(8191, full + 1)));
		end else begin
			w.sequence_req   = 16'($urandom);
			w.timestamp      = $urandom;
			w.packet_size    = 11'($urandom);
			w.packet_samples = 13'($urandom);
			pkt_backlog.push_back(w);
			seq_step = w.sequence_req - gen_seq;
			if (w.packet_size != 0 && w.packet_size <= aplr_pkg::MAX_PAYLOAD_DEF
					&& w.packet_samples != 0 && 32'(w.packet_samples) <= full
					&& seq_step != 0 && seq_step < aplr_pkg::SEQ_HALF) begin
				gen_seq = w.sequence_req;
				gen_ts  = w.timestamp;
				gen_len = w.packet_samples;
			end
		end
	endtask

	task automatic send_directed();
		gen_seq = 16'hFFFD;
		gen_ts  = 32'hFFFF_F000;
		gen_len = '0;
		send_next(16'd1, '0, 11'd1, 13'd960);
		send_next(16'd1, '0, 11'd1275, 13'd5760);
		send_next(16'd1, '0, 11'd100, 13'd1);
		send(gen_seq + 16'd1, $urandom, 11'd0, 13'd960);
		send(gen_seq + 16'd1, $urandom, 11'd1276, 13'd960);
		send(gen_seq + 16'd1, $urandom, 11'd2047, 13'd960);
		send(gen_seq + 16'd1, $urandom, 11'd100, 13'd0);
		send(gen_seq + 16'd1, $urandom, 11'd100, 13'd5761);
		send(gen_seq + 16'd1, $urandom, 11'd100, 13'd8191);
		send(gen_seq, $urandom, 11'd100, 13'd960);
		send(gen_seq + 16'h8000, $urandom, 11'd100, 13'd960);
		send(gen_seq - 16'd1, $urandom, 11'd100, 13'd960);
		send_next(16'd2, 32'd2880, 11'd200, 13'd960);
		send_next(16'd7, 32'd720, 11'd200, 13'd120);
		send_next(16'd3, 32'd200, 11'd200, 13'd480);
		send_next(16'd3, 32'd241, 11'd200, 13'd480);
		send_next(16'd2, 32'd0, 11'd200, 13'd480);
		send_next(16'd1, 32'd5, 11'd200, 13'd480);
		send_next(16'd1, 32'hFFFF_FFFF, 11'd200, 13'd480);
		send_next(16'd8, 32'd840, 11'd200, 13'd480);
		send_next(16'h7FFF, 32'd0, 11'd200, 13'd480);
		send_next(16'd2, 32'd3000, 11'd200, 13'd480);
		send_next(16'd4, 32'd2880, 11'd200, 13'd960);
		send_next(16'd1, 32'd0, 11'd1, 13'd960);
	endtask

	// hold new words back until every due command word has arrived
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pkt_backlog.size() != 0 || pkt_ch.valid || due_cmds.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_rate(input logic [15:0] hz);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= hz;
		@(posedge clk);
		cfg_we   <= 1'b0;
		rate_reg = hz;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pkt_ch.valid && pkt_ch.ready)
				plan_packet(pkt_ch.data);
			if (pkt_ch.valid && !pkt_ch.ready) begin
				// hold the offered word
			end else if (pkt_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				pkt_ch.valid <= 1'b1;
				pkt_ch.data  <= pkt_backlog.pop_front();
			end else begin
				pkt_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (plan_ch.valid && plan_ch.ready)
				check_cmd(plan_ch.data);
			plan_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (long_hold_go)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int unsigned p, k;
		pkt_ch.valid  = 1'b0;
		pkt_ch.data   = '0;
		plan_ch.ready = 1'b0;
		cfg_we        = 1'b0;
		cfg_data      = '0;
		arst_n        = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_directed();
		wait_idle();
		for (p = 0; p < NUM_PHASES; p++) begin
			if (p != 0)
				write_rate(16'(phase_rate[p]));
			send_idle_pct  = (p % 4 == 1) ? 75 : (p % 4 == 3) ? 36 : 0;
			recv_stall_pct = (p % 4 == 2) ? 75 : (p % 4 == 3) ? 36 : 0;
			for (k = 0; k < PHASE_ITEMS / 2; k++)
				send_random();
			if (p == 0) begin
				long_hold_go = 1'b1;
				@(negedge clk);
				long_hold_go = 1'b0;
			end
			wait_idle();
			for (k = PHASE_ITEMS / 2; k < PHASE_ITEMS; k++)
				send_random();
			wait_idle();
		end
		if (fails == 0 && due_cmds.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
